// ===== design/taef_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// taef_pkg
// constants and a function shared by the time-aware exponential filter
// ----------------------------------------------------------------------------
package taef_pkg;
   localparam int TIME_WIDTH = 32;
   localparam int OUT_WIDTH  = 48;
   localparam logic [31:0] EXP_M1_Q32 = 32'd1580030169;
   localparam logic [31:0] TAU_RESET  = 32'd100;
   localparam logic [32:0] ONE_Q32    = 33'h1_0000_0000;
   localparam logic signed [OUT_WIDTH-1:0] OUT_MAX = {1'b0, {(OUT_WIDTH-1){1'b1}}};
   localparam logic signed [OUT_WIDTH-1:0] OUT_MIN = {1'b1, {(OUT_WIDTH-1){1'b0}}};

   // reciprocals of 1..10 in Q0.36, rounded up (1 saturates to all ones), used for exact floor(v/k)
   function automatic logic [35:0] recip_k(input logic [3:0] k);
      logic [35:0] r;
      case (k)
         4'd1:    r = 36'hF_FFFF_FFFF;
         4'd2:    r = 36'h8_0000_0000;
         4'd3:    r = 36'h5_5555_5556;
         4'd4:    r = 36'h4_0000_0000;
         4'd5:    r = 36'h3_3333_3334;
         4'd6:    r = 36'h2_AAAA_AAAB;
         4'd7:    r = 36'h2_4924_924A;
         4'd8:    r = 36'h2_0000_0000;
         4'd9:    r = 36'h1_C71C_71C8;
         4'd10:   r = 36'h1_9999_999A;
         default: r = 36'h0;
      endcase
      return r;
   endfunction
endpackage

// ===== design/taef_divider.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// taef_divider
// restoring divider, one quotient bit per cycle, 64-bit dividend by 32-bit
// ----------------------------------------------------------------------------
module taef_divider (
   input  logic        clock,
   input  logic        reset,
   input  logic        start,
   input  logic [63:0] dividend,
   input  logic [31:0] divisor,
   output logic        done,
   output logic [63:0] quotient,
   output logic [31:0] remainder
);
   logic [63:0] quo_ff, quo_in;
   logic [32:0] rem_ff, rem_in;
   logic [31:0] dvs_ff, dvs_in;
   logic [6:0]  cnt_ff, cnt_in;
   logic        busy_ff, busy_in;
   logic        done_ff, done_in;
   logic [32:0] trial;

   always_comb begin
      quo_in  = quo_ff;
      rem_in  = rem_ff;
      dvs_in  = dvs_ff;
      cnt_in  = cnt_ff;
      busy_in = busy_ff;
      done_in = 1'b0;
      trial   = {rem_ff[31:0], quo_ff[63]};
      if (start) begin
         quo_in  = dividend;
         rem_in  = '0;
         dvs_in  = divisor;
         cnt_in  = 7'd64;
         busy_in = 1'b1;
      end else if (busy_ff) begin
         // shift in next bit and try subtract
         if (trial >= {1'b0, dvs_ff}) begin
            rem_in = trial - {1'b0, dvs_ff};
            quo_in = {quo_ff[62:0], 1'b1};
         end else begin
            rem_in = trial;
            quo_in = {quo_ff[62:0], 1'b0};
         end
         cnt_in = cnt_ff - 7'd1;
         if (cnt_ff == 7'd1) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         cnt_ff  <= '0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
         cnt_ff  <= cnt_in;
      end
      quo_ff <= quo_in;
      rem_ff <= rem_in;
      dvs_ff <= dvs_in;
   end

   assign done      = done_ff;
   assign quotient  = quo_ff;
   assign remainder = rem_ff[31:0];
endmodule

// ===== design/time_aware_exponential_filter_top.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// time_aware_exponential_filter_top
// exponential smoothing filter whose decay depends on elapsed milliseconds
// ----------------------------------------------------------------------------
// One transaction is taken at a time. Two passes of the bit-serial divider
// (dt/tau, then the fraction rem*2^32/tau) dominate each one, then ten steps
// of the exp series and up to sixteen exp(-1) steps run through one shared
// 33x36 multiplier, one product per cycle with a register after it, followed
// by blending. req_tready is high only while the block is idle and no result
// waits in the output register, where the result sits until taken. csr writes
// of zero are ignored.
// ----------------------------------------------------------------------------
module time_aware_exponential_filter_top #(
   parameter int FRAC_BITS    = 16,
   parameter int SAMPLE_WIDTH = 32
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        csr_we,
   input  logic [31:0] csr_wdata,
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [63:0] req_tdata,   // sample [31:0], now_ms [63:32]
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [47:0] rsp_tdata    // filtered [47:0]
);
   import taef_pkg::*;

   // sequencer states
   localparam logic [3:0] S_IDLE  = 4'd0;
   localparam logic [3:0] S_DIV1  = 4'd1;
   localparam logic [3:0] S_DIV2  = 4'd2;
   localparam logic [3:0] S_SER_M = 4'd3;
   localparam logic [3:0] S_SER_D = 4'd4;
   localparam logic [3:0] S_EXP1  = 4'd5;
   localparam logic [3:0] S_BLND1 = 4'd6;
   localparam logic [3:0] S_BLND2 = 4'd7;
   localparam logic [3:0] S_BLND3 = 4'd8;
   localparam logic [3:0] S_OUT   = 4'd9;
   localparam logic [3:0] S_DSTRT = 4'd10;

   localparam int KW = FRAC_BITS + 1;

   logic [3:0]  state_ff, state_in;
   logic [31:0] tau_ff;
   logic signed [47:0] prev_y_ff, prev_y_in;
   logic [31:0] prev_t_ff, prev_t_in;
   logic signed [47:0] xf_ff, xf_in;
   logic [31:0] dt_ff, dt_in;
   logic [4:0]  n_ff, n_in;
   logic [31:0] frac_ff, frac_in;
   logic [32:0] p_ff, p_in;
   logic [3:0]  k_ff, k_in;
   logic [64:0] prod_ff, prod_in;
   logic [KW-1:0] kf_ff, kf_in;
   logic [48:0] mag_ff, mag_in;
   logic        neg_ff, neg_in;
   logic [47:0] rsp_ff, rsp_in;
   logic        rv_ff, rv_in;
   logic        zero_k_ff, zero_k_in;

   // shared multiplier operands
   logic [32:0] mul_a;
   logic [35:0] mul_b;
   logic [68:0] mul_p;

   // divider
   logic        div_start;
   logic [63:0] div_dividend;
   logic        div_done;
   logic [63:0] div_q;
   logic [31:0] div_r;

   taef_divider u_div (
      .clock     (clock),
      .reset     (reset),
      .start     (div_start),
      .dividend  (div_dividend),
      .divisor   (tau_ff),
      .done      (div_done),
      .quotient  (div_q),
      .remainder (div_r)
   );

   // sample sign extension and scaling
   logic signed [SAMPLE_WIDTH-1:0] samp;
   logic signed [63:0] xs;
   logic signed [63:0] xsh;
   assign samp = req_tdata[SAMPLE_WIDTH-1:0];
   assign xs   = 64'(samp);
   assign xsh  = xs <<< FRAC_BITS;

   assign mul_p = {36'd0, mul_a} * {33'd0, mul_b};

   logic signed [49:0] diff;
   logic [48:0] scaled;
   logic signed [49:0] ysum;
   logic [32:0] rnd;

   always_comb begin
      state_in  = state_ff;
      prev_y_in = prev_y_ff;
      prev_t_in = prev_t_ff;
      xf_in     = xf_ff;
      dt_in     = dt_ff;
      n_in      = n_ff;
      frac_in   = frac_ff;
      p_in      = p_ff;
      k_in      = k_ff;
      prod_in   = prod_ff;
      kf_in     = kf_ff;
      mag_in    = mag_ff;
      neg_in    = neg_ff;
      rsp_in    = rsp_ff;
      rv_in     = rv_ff;
      zero_k_in = zero_k_ff;
      div_start = 1'b0;
      div_dividend = {32'd0, dt_ff};
      mul_a     = '0;
      mul_b     = '0;
      diff      = '0;
      scaled    = '0;
      ysum      = '0;
      rnd       = '0;
      if (rv_ff && rsp_tready) rv_in = 1'b0;
      case (state_ff)
         S_IDLE: begin
            if (req_tvalid && !rv_ff) begin
               // saturate xf to 48 bits
               if (xsh > 64'(OUT_MAX))      xf_in = OUT_MAX;
               else if (xsh < 64'(OUT_MIN)) xf_in = OUT_MIN;
               else                         xf_in = xsh[47:0];
               dt_in    = req_tdata[63:32] - prev_t_ff;
               prev_t_in = req_tdata[63:32];
               state_in = S_DSTRT;
            end
         end
         S_DSTRT: begin
            div_start    = 1'b1;
            div_dividend = {32'd0, dt_ff};
            state_in     = S_DIV1;
         end
         S_DIV1: begin
            if (div_done) begin
               zero_k_in = (div_q > 64'd16) || (div_q == 64'd16 && div_r != 32'd0);
               // no exp(-1) steps when the gain is forced to zero
               n_in = zero_k_in ? 5'd0 : div_q[4:0];
               div_start    = 1'b1;
               div_dividend = {div_r, 32'd0};
               state_in     = S_DIV2;
            end
         end
         S_DIV2: begin
            if (div_done) begin
               frac_in  = div_q[31:0];
               p_in     = ONE_Q32;
               k_in     = 4'd10;
               state_in = S_SER_M;
            end
         end
         S_SER_M: begin
            // f * p
            mul_a   = p_ff;
            mul_b   = {4'd0, frac_ff};
            prod_in = mul_p[64:0];
            state_in = S_SER_D;
         end
         S_SER_D: begin
            // floor(t/k) with t < 2^33 via reciprocal
            mul_a = prod_ff[64:32];
            mul_b = recip_k(k_ff);
            p_in  = ONE_Q32 - {1'b0, mul_p[67:36]};
            if (k_ff == 4'd1) p_in = ONE_Q32 - prod_ff[64:32];
            if (k_ff == 4'd1) state_in = S_EXP1;
            else begin
               k_in = k_ff - 4'd1;
               state_in = S_SER_M;
            end
         end
         S_EXP1: begin
            if (n_ff != 5'd0) begin
               mul_a = p_ff;
               mul_b = {4'd0, EXP_M1_Q32};
               p_in  = mul_p[64:32];
               n_in  = n_ff - 5'd1;
            end else begin
               rnd   = p_ff + (33'd1 << (31 - FRAC_BITS));
               kf_in = zero_k_ff ? '0 : rnd[32-FRAC_BITS +: KW];
               state_in = S_BLND1;
            end
         end
         S_BLND1: begin
            diff   = 50'(prev_y_ff) - 50'(xf_ff);
            neg_in = diff[49];
            mag_in = diff[49] ? 49'(-diff) : diff[48:0];
            state_in = S_BLND2;
         end
         S_BLND2: begin
            // high part a*K, magnitude < 2^49 so a < 2^(49-F)
            mul_a   = 33'(mag_ff >> FRAC_BITS);
            mul_b   = 36'(kf_ff);
            prod_in = mul_p[64:0];
            state_in = S_BLND3;
         end
         S_BLND3: begin
            mul_a  = 33'(mag_ff[FRAC_BITS-1:0]);
            mul_b  = 36'(kf_ff);
            scaled = 49'(prod_ff) + 49'(mul_p >> FRAC_BITS);
            if (neg_ff && (mul_p[FRAC_BITS-1:0] != '0)) scaled = scaled + 49'd1;
            ysum = neg_ff ? 50'(xf_ff) - 50'(scaled) : 50'(xf_ff) + 50'(scaled);
            if (ysum > 50'(OUT_MAX))      prev_y_in = OUT_MAX;
            else if (ysum < 50'(OUT_MIN)) prev_y_in = OUT_MIN;
            else                          prev_y_in = ysum[47:0];
            state_in = S_OUT;
         end
         S_OUT: begin
            rsp_in   = prev_y_ff;
            rv_in    = 1'b1;
            state_in = S_IDLE;
         end
         default: state_in = S_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff  <= S_IDLE;
         tau_ff    <= TAU_RESET;
         prev_y_ff <= '0;
         prev_t_ff <= '0;
         rv_ff     <= 1'b0;
      end else begin
         state_ff  <= state_in;
         prev_y_ff <= prev_y_in;
         prev_t_ff <= prev_t_in;
         rv_ff     <= rv_in;
         // zero time constant writes are dropped
         if (csr_we && csr_wdata != 32'd0) tau_ff <= csr_wdata;
      end
      xf_ff     <= xf_in;
      dt_ff     <= dt_in;
      n_ff      <= n_in;
      frac_ff   <= frac_in;
      p_ff      <= p_in;
      k_ff      <= k_in;
      prod_ff   <= prod_in;
      kf_ff     <= kf_in;
      mag_ff    <= mag_in;
      neg_ff    <= neg_in;
      rsp_ff    <= rsp_in;
      zero_k_ff <= zero_k_in;
   end

   assign req_tready = (state_ff == S_IDLE) && !rv_ff;
   assign rsp_tvalid = rv_ff;
   assign rsp_tdata  = rsp_ff;
endmodule
